// ----- design/uart_baud_divisor_calc_assert.svh -----
// Assertion macros shared by the baud divisor calculator RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef UART_BAUD_DIVISOR_CALC_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication with a fixed delay in cycles, checked outside reset.
`define UBD_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
	else $error(msg);

`endif

// ----- design/ubd_pkg.sv -----
// Shared types and constants for the UART baud divisor calculator.
// No dependencies; every design module imports this package.
package ubd_pkg;

	// Field widths.
	localparam int CLK_W    = 32;
	localparam int BAUD_W   = 24;
	localparam int MANT_W   = 12;
	localparam int FRAC_W   = 4;
	localparam int WORD_W   = 16;
	localparam int STATUS_W = 2;

	// Long division: quotient bits retired per stage and number of stages.
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = 10;
	localparam int NUM_W      = DIV_STEP * DIV_STAGES;
	localparam int DEN_W      = BAUD_W + 1;

	// Width of the quotient once it is known to be below the saturation limit.
	localparam int T_W   = 22;
	localparam int REM_W = 10;
	localparam int X_W   = 15;
	localparam int FR_W  = 5;

	// Arithmetic constants.
	localparam logic [7:0]      MUL_CLOCK  = 8'd125;
	localparam logic [T_W-1:0]  DEC_SCALE  = 22'd1000;
	localparam logic [X_W-1:0]  ROUND_HALF = 15'd500;
	localparam logic [T_W-1:0]  SAT_LIMIT  = 22'd4096000;
	// ceil(2^32 / 1000), exact for quotients below SAT_LIMIT.
	localparam logic [22:0]     RECIP_MANT = 23'd4294968;
	localparam int              RECIP_MANT_SH = 32;
	// ceil(2^24 / 1000), exact for numerators below 16500.
	localparam logic [X_W-1:0]  RECIP_FRAC = 15'd16778;
	localparam int              RECIP_FRAC_SH = 24;

	// Cycles from an accepted request to its result strobe.
	localparam int LATENCY = DIV_STAGES + 5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_CLK0  = 2'd1,
		ST_BAUD0 = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	// Request attributes that ride alongside the arithmetic.
	typedef struct packed {
		logic clk_zero;
		logic baud_zero;
		logic over8;
	} side_t;

endpackage

// ----- design/ubd_front.sv -----
// Input stage: forms the scaled clock numerator and the baud denominator.
// Depends on ubd_pkg.
module ubd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ubd_pkg::CLK_W-1:0]   clock_hz,
	input  logic [ubd_pkg::BAUD_W-1:0]  baud_rate,
	input  logic                        oversample_by_8,
	output logic                        valid_s1,
	output logic [ubd_pkg::NUM_W-1:0]   num_s1,
	output logic [ubd_pkg::DEN_W-1:0]   den_s1,
	output ubd_pkg::side_t              side_s1
);
	import ubd_pkg::*;

	logic [NUM_W-1:0] num_d;
	logic [DEN_W-1:0] den_d;
	side_t            side_d;

	// Numerator is clock times 125; denominator is baud, doubled when oversampling by 16.
	always_comb begin
		num_d = NUM_W'(clock_hz) * NUM_W'(MUL_CLOCK);
		den_d = oversample_by_8 ? {1'b0, baud_rate} : {baud_rate, 1'b0};
		side_d.clk_zero  = (clock_hz == '0);
		side_d.baud_zero = (baud_rate == '0);
		side_d.over8     = oversample_by_8;
	end

	// Valid flag is control state and resets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		num_s1  <= num_d;
		den_s1  <= den_d;
		side_s1 <= side_d;
	end

endmodule

// ----- design/ubd_divider.sv -----
// Pipelined restoring divider: DIV_STEP quotient bits per register stage.
// Depends on ubd_pkg.
module ubd_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_in,
	input  logic [ubd_pkg::NUM_W-1:0]  num_in,
	input  logic [ubd_pkg::DEN_W-1:0]  den_in,
	input  ubd_pkg::side_t             side_in,
	output logic                       valid_out,
	output logic [ubd_pkg::NUM_W-1:0]  quo_out,
	output ubd_pkg::side_t             side_out
);
	import ubd_pkg::*;

	// Stage registers; the dividend, remainder and divisor are dropped after the last stage.
	logic             valid_s [DIV_STAGES];
	logic [NUM_W-1:0] quo_s   [DIV_STAGES];
	side_t            side_s  [DIV_STAGES];
	logic [NUM_W-1:0] num_s   [DIV_STAGES-1];
	logic [DEN_W-1:0] rem_s   [DIV_STAGES-1];
	logic [DEN_W-1:0] den_s   [DIV_STAGES-1];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic             v_in;
		logic [NUM_W-1:0] n_in;
		logic [NUM_W-1:0] q_in;
		logic [DEN_W-1:0] r_in;
		logic [DEN_W-1:0] d_in;
		side_t            s_in;
		logic [NUM_W-1:0] n_nx;
		logic [NUM_W-1:0] q_nx;
		logic [DEN_W-1:0] r_nx;

		// Stage inputs come from the ports or from the previous stage.
		if (k == 0) begin : g_head
			assign v_in = valid_in;
			assign n_in = num_in;
			assign q_in = '0;
			assign r_in = '0;
			assign d_in = den_in;
			assign s_in = side_in;
		end else begin : g_body
			assign v_in = valid_s[k-1];
			assign n_in = num_s[k-1];
			assign q_in = quo_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
		end

		// For each of DIV_STEP bits: shift in one dividend bit, subtract if possible, record the quotient bit.
		always_comb begin : step
			logic [DEN_W:0] trial;
			n_nx  = n_in;
			q_nx  = q_in;
			r_nx  = r_in;
			trial = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				trial = {r_nx, n_nx[NUM_W-1]};
				n_nx  = {n_nx[NUM_W-2:0], 1'b0};
				if (trial >= {1'b0, d_in}) begin
					trial = trial - {1'b0, d_in};
					q_nx  = {q_nx[NUM_W-2:0], 1'b1};
				end else begin
					q_nx  = {q_nx[NUM_W-2:0], 1'b0};
				end
				r_nx = trial[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k]  <= q_nx;
			side_s[k] <= s_in;
		end

		// Working operands are only kept while later stages need them.
		if (k < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				num_s[k] <= n_nx;
				rem_s[k] <= r_nx;
				den_s[k] <= d_in;
			end
		end
	end

	assign valid_out = valid_s[DIV_STAGES-1];
	assign quo_out   = quo_s[DIV_STAGES-1];
	assign side_out  = side_s[DIV_STAGES-1];

endmodule

// ----- design/ubd_post.sv -----
// Back end: splits the quotient into mantissa and rounded fraction, handles
// the rounding carry, saturation and zero inputs, and registers the result.
// Depends on ubd_pkg and uart_baud_divisor_calc_assert.svh.
`include "uart_baud_divisor_calc_assert.svh"

module ubd_post (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	input  logic [ubd_pkg::NUM_W-1:0]     quo_in,
	input  ubd_pkg::side_t                side_in,
	output logic                          done,
	output logic                          write_enable,
	output logic [ubd_pkg::WORD_W-1:0]    divisor_word,
	output logic [ubd_pkg::MANT_W-1:0]    mantissa,
	output logic [ubd_pkg::FRAC_W-1:0]    fraction,
	output logic [ubd_pkg::STATUS_W-1:0]  status
);
	import ubd_pkg::*;

	logic              valid_s12, valid_s13, valid_s14, valid_s15;
	side_t             side_s12, side_s13, side_s14, side_s15;
	logic              big_s12, big_s13, big_s14;
	logic [T_W-1:0]    t_s12;
	logic [MANT_W-1:0] q_s12, q_s13, q_s14;
	logic [X_W-1:0]    x_s13;
	logic [FR_W-1:0]   fr_s14;
	logic              we_s15;
	logic [MANT_W-1:0] mant_s15;
	logic [FRAC_W-1:0] frac_s15;
	status_t           st_s15;

	logic [44:0]       mant_prod;
	logic [T_W-1:0]    back_mul;
	logic [REM_W-1:0]  rem_d;
	logic [X_W-1:0]    x_d;
	logic [29:0]       frac_prod;
	logic [FR_W-1:0]   limit;
	logic              carry;
	logic [FR_W-1:0]   fr_adj;
	logic [MANT_W:0]   mant_c;
	logic              sat;
	logic              we_d;
	logic [MANT_W-1:0] mant_d;
	logic [FRAC_W-1:0] frac_d;
	status_t           st_d;

	// Stage 12: saturation test and reciprocal multiply for quotient / 1000.
	assign mant_prod = 45'(quo_in[T_W-1:0]) * 45'(RECIP_MANT);

	// Stage 13: remainder and the scaled, rounded numerator of the fraction.
	always_comb begin
		back_mul = T_W'(q_s12) * DEC_SCALE;
		rem_d    = REM_W'(t_s12 - back_mul);
		x_d      = side_s12.over8 ? X_W'({rem_d, 3'b000}) : X_W'({rem_d, 4'b0000});
		x_d      = x_d + ROUND_HALF;
	end

	// Stage 14: reciprocal multiply for the rounded fraction.
	assign frac_prod = 30'(x_s13) * 30'(RECIP_FRAC);

	// Stage 15: rounding carry, saturation and the special input cases.
	always_comb begin
		limit  = side_s14.over8 ? FR_W'(8) : FR_W'(16);
		carry  = (fr_s14 >= limit);
		fr_adj = carry ? fr_s14 - limit : fr_s14;
		mant_c = {1'b0, q_s14} + (MANT_W+1)'(carry);
		sat    = big_s14 | mant_c[MANT_W];
		if (side_s14.clk_zero) begin
			we_d = 1'b0; mant_d = '0; frac_d = '0; st_d = ST_CLK0;
		end else if (side_s14.baud_zero) begin
			we_d = 1'b0; mant_d = '0; frac_d = '0; st_d = ST_BAUD0;
		end else if (sat) begin
			we_d   = 1'b1;
			mant_d = '1;
			frac_d = FRAC_W'(limit - FR_W'(1));
			st_d   = ST_SAT;
		end else begin
			we_d   = 1'b1;
			mant_d = mant_c[MANT_W-1:0];
			frac_d = fr_adj[FRAC_W-1:0];
			st_d   = ST_OK;
		end
	end

	// Valid flags move down the pipe every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
			valid_s15 <= 1'b0;
		end else begin
			valid_s12 <= valid_in;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
			valid_s15 <= valid_s14;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		side_s12 <= side_in;
		big_s12  <= (quo_in >= NUM_W'(SAT_LIMIT));
		t_s12    <= quo_in[T_W-1:0];
		q_s12    <= mant_prod[RECIP_MANT_SH +: MANT_W];

		side_s13 <= side_s12;
		big_s13  <= big_s12;
		q_s13    <= q_s12;
		x_s13    <= x_d;

		side_s14 <= side_s13;
		big_s14  <= big_s13;
		q_s14    <= q_s13;
		fr_s14   <= frac_prod[RECIP_FRAC_SH +: FR_W];

		side_s15 <= side_s14;
		we_s15   <= we_d;
		mant_s15 <= mant_d;
		frac_s15 <= frac_d;
		st_s15   <= st_d;
	end

	assign done         = valid_s15;
	assign write_enable = we_s15;
	assign mantissa     = mant_s15;
	assign fraction     = frac_s15;
	assign divisor_word = {mant_s15, frac_s15};
	assign status       = STATUS_W'(st_s15);

	// Write enable follows status, saturation clamps, 8x fractions stay below 8, skips are zero.
	`UBD_ASSERT_IMP(a_we_status, done, write_enable == (st_s15 == ST_OK || st_s15 == ST_SAT), "write enable disagrees with status")
	`UBD_ASSERT_IMP(a_sat_mant, done && st_s15 == ST_SAT, mant_s15 == '1 && (frac_s15 == 4'd15 || frac_s15 == 4'd7), "saturated result not clamped")
	`UBD_ASSERT_IMP(a_over8_frac, done && side_s15.over8, !frac_s15[FRAC_W-1], "fraction out of range when oversampling by 8")
	`UBD_ASSERT_IMP(a_skip_zero, done && !write_enable, mant_s15 == '0 && frac_s15 == '0, "skipped result carries a nonzero divisor")

endmodule

// ----- design/uart_baud_divisor_calc.sv -----
// Top level of the UART fractional baud divisor calculator.
// Depends on ubd_pkg, ubd_front, ubd_divider, ubd_post and the assertion header.
//
//   Channel   Handshake              Payload
//   request   start (in), busy (out) clock_hz, baud_rate, oversample_by_8
//   result    done (out, strobe)     write_enable, divisor_word, mantissa,
//                                    fraction, status
//
// A request is taken in every cycle; busy never rises.
// Each result strobes done once its request has passed one input stage,
// ten stages of the restoring divider at four quotient bits each, and four
// stages that split, round and clamp the result.
// Reset clears only the valid flags; the payload registers are not reset.
// The receiver cannot stall, so results leave the pipe as they arrive.
`include "uart_baud_divisor_calc_assert.svh"

module uart_baud_divisor_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ubd_pkg::CLK_W-1:0]     clock_hz,
	input  logic [ubd_pkg::BAUD_W-1:0]    baud_rate,
	input  logic                          oversample_by_8,
	output logic                          done,
	output logic                          write_enable,
	output logic [ubd_pkg::WORD_W-1:0]    divisor_word,
	output logic [ubd_pkg::MANT_W-1:0]    mantissa,
	output logic [ubd_pkg::FRAC_W-1:0]    fraction,
	output logic [ubd_pkg::STATUS_W-1:0]  status
);
	import ubd_pkg::*;

	logic             valid_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	side_t            side_s1;
	logic             div_valid;
	logic [NUM_W-1:0] div_quo;
	side_t            div_side;

	// The pipeline never backs up.
	assign busy = 1'b0;

	// Numerator and denominator formation.
	ubd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.clock_hz        (clock_hz),
		.baud_rate       (baud_rate),
		.oversample_by_8 (oversample_by_8),
		.valid_s1        (valid_s1),
		.num_s1          (num_s1),
		.den_s1          (den_s1),
		.side_s1         (side_s1)
	);

	// Long division.
	ubd_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.num_in    (num_s1),
		.den_in    (den_s1),
		.side_in   (side_s1),
		.valid_out (div_valid),
		.quo_out   (div_quo),
		.side_out  (div_side)
	);

	// Mantissa, fraction and status.
	ubd_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (div_valid),
		.quo_in       (div_quo),
		.side_in      (div_side),
		.done         (done),
		.write_enable (write_enable),
		.divisor_word (divisor_word),
		.mantissa     (mantissa),
		.fraction     (fraction),
		.status       (status)
	);

	// Every accepted request produces its strobe after the fixed latency.
	`UBD_ASSERT_DLY(a_latency, start && !busy, LATENCY, done, "request did not produce a result on time")

endmodule
